>>> design/mean_squared_displacement_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean squared displacement core
// Clocked, reset-qualified property shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MEAN_SQUARED_DISPLACEMENT_CORE_MACROS_SVH
`define MEAN_SQUARED_DISPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication.
`define MSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Types, widths and the lag table of the mean squared displacement core.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int PID_W  = 6;
    localparam int FRM_W  = 8;
    localparam int CRD_W  = 24;
    localparam int D_W    = 25;
    localparam int S1_W   = 40;
    localparam int S2_W   = 64;
    localparam int VAR_W  = 48;
    localparam int TOT_W  = 50;
    localparam int CNT_W  = 15;
    localparam int LAG_W  = 8;
    localparam int LAGT_W = 13;
    localparam int DIMS_W = 2;
    localparam int AX_N   = 3;
    localparam int POS_W  = AX_N * CRD_W;

    localparam int DEF_MAX_PARTICLES = 64;
    localparam int DEF_MAX_FRAMES    = 256;
    localparam int DEF_MAX_AXES      = 3;
    localparam int DEF_MAX_LAGS      = 64;

    localparam int LAG_SEQ_N = 150;
    localparam int LAG_TAB_D = 256;
    localparam logic [LAGT_W-1:0] LAG_CAP = '1;

    typedef logic [LAG_TAB_D-1:0][LAGT_W-1:0] t_lag_tab;

    typedef struct packed {
        logic [PID_W-1:0]        particle_id;
        logic [FRM_W-1:0]        frame_no;
        logic signed [CRD_W-1:0] coord_x;
        logic signed [CRD_W-1:0] coord_y;
        logic signed [CRD_W-1:0] coord_z;
        logic                    last_record;
    } t_rec;

    typedef struct packed {
        logic [LAG_W-1:0]        lag;
        logic signed [CRD_W-1:0] mean_dx;
        logic signed [CRD_W-1:0] mean_dy;
        logic signed [CRD_W-1:0] mean_dz;
        logic [VAR_W-1:0]        var_x;
        logic [VAR_W-1:0]        var_y;
        logic [VAR_W-1:0]        var_z;
        logic [TOT_W-1:0]        var_total;
        logic [CNT_W-1:0]        pair_count;
        logic                    last_row;
    } t_res;

    // Geometric lags round(1.15^i), 48 fraction bits, repeats dropped.
    // Entries past the useful range hold LAG_CAP, which never qualifies.
    function automatic t_lag_tab f_lag_tab();
        logic [79:0]       v;
        logic [79:0]       j;
        logic [LAGT_W-1:0] jc;
        int                n;
        t_lag_tab          tab;
        for (int e = 0; e < LAG_TAB_D; e++) begin
            tab[e] = LAG_CAP;
        end
        v = 80'd1 << 48;
        n = 0;
        for (int i = 0; i < LAG_SEQ_N; i++) begin
            j  = (v + (80'd1 << 47)) >> 48;
            jc = (j >= 80'(LAG_CAP)) ? LAG_CAP : j[LAGT_W-1:0];
            if (n == 0 || jc != tab[n-1]) begin
                tab[n] = jc;
                n++;
            end
            if (jc != LAG_CAP) begin
                v = v + (v * 80'd3) / 80'd20;
            end
        end
        return tab;
    endfunction

    localparam t_lag_tab LAG_TAB = f_lag_tab();

endpackage

>>> design/msd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module msd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/mean_squared_displacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_squared_displacement_core
// Loads particle positions, then emits per-lag displacement mean and variance.
// ----------------------------------------------------------------------------
// Load: one record per cycle while idle, no result; a record with last_record starts a run.
// Run: per lag, every (particle, frame) slot pair is read from the
//   single-read-port store, each present pair is summed per used axis,
//   and each used axis takes two 64-step divisions; one row per lag.
// Clear: after reset and after each run the present-mark RAM is swept, one
//   slot per cycle (MAX_PARTICLES*MAX_FRAMES slots, 16384 by default); busy.
// Results are strobed for one cycle; the receiver cannot stall.
module mean_squared_displacement_core
    import msd_pkg::*;
#(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
    parameter int MAX_AXES      = DEF_MAX_AXES,
    parameter int MAX_LAGS      = DEF_MAX_LAGS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_rec              i_rec,
    output t_res              o_res,
    output logic              o_strobe,
    input  logic              i_cfg_we,
    input  logic [DIMS_W-1:0] i_cfg_wdata
);
    `include "mean_squared_displacement_core_macros.svh"

    localparam int SLOTS  = MAX_PARTICLES * MAX_FRAMES;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int FC_W   = FRM_W + 1;   // frame count / in-frame index
    localparam int PC_W   = PID_W + 1;   // particle count
    localparam int IDX_W  = 8;
    localparam int ROW_W  = $bits(t_res);

    // Sequencer codes.
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_LAG   = 5'd2;
    localparam logic [4:0] S_RDA   = 5'd3;
    localparam logic [4:0] S_RDB   = 5'd4;
    localparam logic [4:0] S_PAIR  = 5'd5;
    localparam logic [4:0] S_DIFF  = 5'd6;
    localparam logic [4:0] S_MUL   = 5'd7;
    localparam logic [4:0] S_ACC   = 5'd8;
    localparam logic [4:0] S_NEXT  = 5'd9;
    localparam logic [4:0] S_FIN   = 5'd10;
    localparam logic [4:0] S_D1S   = 5'd11;
    localparam logic [4:0] S_D1    = 5'd12;
    localparam logic [4:0] S_D2S   = 5'd13;
    localparam logic [4:0] S_D2    = 5'd14;
    localparam logic [4:0] S_SQ    = 5'd15;
    localparam logic [4:0] S_VAR   = 5'd16;
    localparam logic [4:0] S_EMIT  = 5'd17;

    logic [4:0]        r_state;
    logic [DIMS_W-1:0] r_cfg_dims;
    logic [DIMS_W-1:0] r_dims;
    logic [FRM_W-1:0]  r_hf;
    logic [PID_W-1:0]  r_hp;
    logic [SLOT_W-1:0] r_clr_addr;
    logic [IDX_W-1:0]  r_idx;
    logic [FC_W-1:0]   r_lag;
    logic [FC_W-1:0]   r_tlim;
    logic [FC_W-1:0]   r_t;
    logic [PC_W-1:0]   r_p;
    logic [SLOT_W-1:0] r_base;
    logic [CNT_W-1:0]  r_count;
    logic [DIMS_W-1:0] r_k;
    logic [POS_W-1:0]  r_pos_a;
    logic [POS_W-1:0]  r_pos_b;
    logic signed [D_W-1:0]   r_d;
    logic signed [2*D_W-1:0] r_sq;
    logic signed [S1_W-1:0]  r_s1 [AX_N];
    logic [S2_W-1:0]   r_s2 [AX_N];
    logic [S2_W-1:0]   r_div_num;
    logic [CNT_W-1:0]  r_div_rem;
    logic [5:0]        r_div_cnt;
    logic              r_neg;
    logic [D_W-1:0]    r_q;
    logic [S2_W-1:0]   r_q2;
    logic [2*D_W-1:0]  r_msq;
    t_res              r_row;

    // Memory ports.
    logic              pos_we;
    logic [SLOT_W-1:0] pos_waddr;
    logic [POS_W-1:0]  pos_wdata;
    logic [POS_W-1:0]  pos_rdata;
    logic              mark_we;
    logic [SLOT_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic              mark_rdata;
    logic [SLOT_W-1:0] rd_addr;

    logic              acc;
    logic              rec_ok;
    logic [SLOT_W-1:0] rec_slot;
    logic [FC_W-1:0]   frames;
    logic [PC_W-1:0]   parts;
    logic [LAGT_W-1:0] cur_lag;
    logic              cur_ok;
    logic [IDX_W-1:0]  nidx;
    logic              next_ok;
    logic [SLOT_W-1:0] addr_a;
    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;
    logic [S1_W-1:0]   s1_mag;
    logic [S2_W-1:0]   var_raw;
    logic [VAR_W-1:0]  var_sat;
    logic signed [CRD_W-1:0] mean_sat;
    logic [DIMS_W-1:0] dims_eff;

    assign busy     = (r_state != S_IDLE);
    assign acc      = start && !busy;
    assign rec_ok   = (int'(i_rec.particle_id) < MAX_PARTICLES) &&
                      (int'(i_rec.frame_no) < MAX_FRAMES);
    assign rec_slot = SLOT_W'(int'(i_rec.particle_id) * MAX_FRAMES + int'(i_rec.frame_no));
    assign frames   = FC_W'(r_hf) + FC_W'(1);
    assign parts    = PC_W'(r_hp) + PC_W'(1);

    // Lag walk: list ends at the first lag not below the frame count, or after MAX_LAGS entries.
    assign cur_lag  = LAG_TAB[r_idx];
    assign cur_ok   = (int'(r_idx) < MAX_LAGS) && (cur_lag < LAGT_W'(frames));
    assign nidx     = r_idx + IDX_W'(1);
    assign next_ok  = (int'(nidx) < MAX_LAGS) && (LAG_TAB[nidx] < LAGT_W'(frames));

    assign addr_a   = r_base + SLOT_W'(r_t);
    assign rd_addr  = (r_state == S_RDB) ? (addr_a + SLOT_W'(r_lag)) : addr_a;

    always_comb begin
        dims_eff = r_cfg_dims;
        if (r_cfg_dims == '0) begin
            dims_eff = DIMS_W'(1);
        end else if (int'(r_cfg_dims) > MAX_AXES) begin
            dims_eff = DIMS_W'(MAX_AXES);
        end
    end

    // Write side: clearing sweep or record load.
    assign pos_we     = acc && rec_ok;
    assign pos_waddr  = rec_slot;
    assign pos_wdata  = {i_rec.coord_z, i_rec.coord_y, i_rec.coord_x};
    assign mark_we    = (r_state == S_CLEAR) || (acc && rec_ok);
    assign mark_waddr = (r_state == S_CLEAR) ? r_clr_addr : rec_slot;
    assign mark_wdata = (r_state != S_CLEAR);

    // Restoring division step, one quotient bit per cycle.
    assign rem_sh = {r_div_rem, r_div_num[S2_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_count});

    assign s1_mag = r_s1[r_k][S1_W-1] ? S1_W'(-r_s1[r_k]) : S1_W'(r_s1[r_k]);

    always_comb begin
        var_raw = (r_q2 > S2_W'(r_msq)) ? (r_q2 - S2_W'(r_msq)) : '0;
        var_sat = (var_raw > S2_W'({VAR_W{1'b1}})) ? '1 : var_raw[VAR_W-1:0];
        if (!r_neg) begin
            mean_sat = (r_q > D_W'(24'h7FFFFF)) ? CRD_W'(24'h7FFFFF) : CRD_W'(r_q);
        end else begin
            mean_sat = (r_q > D_W'(24'h800000)) ? CRD_W'(24'h800000)
                                                 : CRD_W'(-$signed({1'b0, r_q}));
        end
    end

    msd_ram #(.WIDTH(POS_W), .DEPTH(SLOTS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pos_rdata)
    );

    msd_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (rd_addr),
        .o_rdata (mark_rdata)
    );

    logic r_mark_a;

    // Payload and datapath registers: no reset needed.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LAG: begin
                r_lag   <= cur_lag[FC_W-1:0];
                r_tlim  <= frames - cur_lag[FC_W-1:0];
                r_t     <= '0;
                r_p     <= '0;
                r_base  <= '0;
                r_count <= '0;
                // Clear the row and load its lag.
                r_row   <= t_res'({cur_lag[LAG_W-1:0], {(ROW_W-LAG_W){1'b0}}});
                for (int i = 0; i < AX_N; i++) begin
                    r_s1[i] <= '0;
                    r_s2[i] <= '0;
                end
            end
            S_RDB: begin
                // Hold the earlier frame's word.
                r_pos_a  <= pos_rdata;
                r_mark_a <= mark_rdata;
            end
            S_PAIR: begin
                r_pos_b <= pos_rdata;
                r_k     <= '0;
                if (r_mark_a && mark_rdata) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            S_DIFF: begin
                r_d <= D_W'($signed(r_pos_b[r_k*CRD_W +: CRD_W]))
                     - D_W'($signed(r_pos_a[r_k*CRD_W +: CRD_W]));
            end
            S_MUL: begin
                r_sq       <= r_d * r_d;
                r_s1[r_k]  <= r_s1[r_k] + S1_W'(r_d);
            end
            S_ACC: begin
                r_s2[r_k] <= r_s2[r_k] + S2_W'($unsigned(r_sq));
                r_k       <= r_k + DIMS_W'(1);
            end
            S_NEXT: begin
                if (r_t == r_tlim - FC_W'(1)) begin
                    r_t    <= '0;
                    r_p    <= r_p + PC_W'(1);
                    r_base <= r_base + SLOT_W'(MAX_FRAMES);
                end else begin
                    r_t <= r_t + FC_W'(1);
                end
            end
            S_FIN: begin
                r_k   <= '0;
                // Pair count and final-row flag are known once the walk ends.
                r_row <= t_res'({r_row[ROW_W-1:CNT_W+1], r_count, !next_ok});
            end
            S_D1S: begin
                r_neg     <= r_s1[r_k][S1_W-1];
                r_div_num <= S2_W'(s1_mag) + S2_W'(r_count >> 1);
                r_div_rem <= '0;
                r_div_cnt <= '0;
            end
            S_D1, S_D2: begin
                r_div_num <= {r_div_num[S2_W-2:0], rem_ge};
                r_div_rem <= rem_ge ? CNT_W'(rem_sh - {1'b0, r_count}) : rem_sh[CNT_W-1:0];
                r_div_cnt <= r_div_cnt + 6'd1;
            end
            S_D2S: begin
                r_q       <= r_div_num[D_W-1:0];
                r_div_num <= r_s2[r_k] + S2_W'(r_count >> 1);
                r_div_rem <= '0;
                r_div_cnt <= '0;
            end
            S_SQ: begin
                r_q2  <= r_div_num;
                r_msq <= r_q * r_q;
            end
            S_VAR: begin
                case (r_k)
                    2'd0: begin
                        r_row.mean_dx <= mean_sat;
                        r_row.var_x   <= var_sat;
                    end
                    2'd1: begin
                        r_row.mean_dy <= mean_sat;
                        r_row.var_y   <= var_sat;
                    end
                    default: begin
                        r_row.mean_dz <= mean_sat;
                        r_row.var_z   <= var_sat;
                    end
                endcase
                r_row.var_total <= r_row.var_total + TOT_W'(var_sat);
                r_k <= r_k + DIMS_W'(1);
            end
            S_EMIT: begin
                o_res <= r_row;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cfg_dims <= DIMS_W'(2);
            r_dims     <= DIMS_W'(2);
            r_hf       <= '0;
            r_hp       <= '0;
            r_idx      <= '0;
            o_strobe   <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_cfg_dims <= i_cfg_wdata;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SLOT_W'(1);
                    if (int'(r_clr_addr) == SLOTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        if (rec_ok) begin
                            if (i_rec.frame_no > r_hf) r_hf <= i_rec.frame_no;
                            if (i_rec.particle_id > r_hp) r_hp <= i_rec.particle_id;
                        end
                        if (i_rec.last_record) begin
                            r_idx   <= '0;
                            r_dims  <= dims_eff;
                            r_state <= S_LAG;
                        end
                    end
                end
                S_LAG: begin
                    if (cur_ok) begin
                        r_state <= S_RDA;
                    end else begin
                        // Run over: drop the extents and sweep the marks.
                        r_hf       <= '0;
                        r_hp       <= '0;
                        r_clr_addr <= '0;
                        r_state    <= S_CLEAR;
                    end
                end
                S_RDA:  r_state <= S_RDB;
                S_RDB:  r_state <= S_PAIR;
                S_PAIR: r_state <= (r_mark_a && mark_rdata) ? S_DIFF : S_NEXT;
                S_DIFF: r_state <= S_MUL;
                S_MUL:  r_state <= S_ACC;
                S_ACC:  r_state <= (r_k == r_dims - DIMS_W'(1)) ? S_NEXT : S_DIFF;
                S_NEXT: begin
                    if (r_t == r_tlim - FC_W'(1) && r_p == parts - PC_W'(1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RDA;
                    end
                end
                S_FIN:  r_state <= (r_count == '0) ? S_EMIT : S_D1S;
                S_D1S:  r_state <= S_D1;
                S_D1:   r_state <= (r_div_cnt == 6'd63) ? S_D2S : S_D1;
                S_D2S:  r_state <= S_D2;
                S_D2:   r_state <= (r_div_cnt == 6'd63) ? S_SQ : S_D2;
                S_SQ:   r_state <= S_VAR;
                S_VAR:  r_state <= (r_k == r_dims - DIMS_W'(1)) ? S_EMIT : S_D1S;
                S_EMIT: begin
                    o_strobe <= 1'b1;
                    r_idx    <= nidx;
                    r_state  <= S_LAG;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // Checks.
    `MSD_ASSERT_NOW(a_row_in_run, o_strobe, busy, "result row outside a run")
    `MSD_ASSERT_NEXT(a_row_spacing, o_strobe, !o_strobe, "rows on adjacent cycles")
    `MSD_ASSERT_NEXT(a_last_starts, acc && i_rec.last_record, busy, "last beat did not start run")
    `MSD_ASSERT_NOW(a_lag_nonzero, o_strobe, o_res.lag != '0, "row with zero lag")

endmodule
